FILE: sv/oidl_pkg.sv
// ----------------------------------------------------------------------------
// oidl_pkg: shared types and constants of the ordered id list engine
// Sizes of the list, command and status codes, the control group that the
// top level broadcasts to every list cell, and field conversion helpers.
// ----------------------------------------------------------------------------
package oidl_pkg;

    // list size and id width
    localparam int DEPTH    = 32;
    localparam int ID_WIDTH = 64;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);

    // port field widths
    localparam int CMD_FW    = 3;
    localparam int ID_FW     = 64;
    localparam int STATUS_FW = 2;
    localparam int COUNT_FW  = 6;

    typedef logic [ID_WIDTH-1:0] t_id;
    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [CNT_W-1:0]    t_cnt;

    // command codes
    localparam logic [CMD_FW-1:0] CMD_PUSH_TAIL = 3'd0;
    localparam logic [CMD_FW-1:0] CMD_PUSH_HEAD = 3'd1;
    localparam logic [CMD_FW-1:0] CMD_REMOVE    = 3'd2;
    localparam logic [CMD_FW-1:0] CMD_POP_HEAD  = 3'd3;
    localparam logic [CMD_FW-1:0] CMD_POP_TAIL  = 3'd4;
    localparam logic [CMD_FW-1:0] CMD_FIND      = 3'd5;

    // status codes
    localparam logic [STATUS_FW-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_FW-1:0] STAT_MISS = 2'd1;
    localparam logic [STATUS_FW-1:0] STAT_FULL = 2'd2;

    // per-cycle update broadcast to the cells
    typedef struct packed {
        logic push_tail;   // cell at the current count takes the new id
        logic push_head;   // every cell takes its left neighbour, cell 0 the new id
        logic remove_hit;  // cells at and after the first match take the right neighbour
        logic pop_head;    // every cell takes its right neighbour
    } t_cell_ctl;

    // zero-extend a stored id into the port field
    function automatic logic [ID_FW-1:0] id_to_field(input t_id id);
        logic [ID_FW+ID_WIDTH-1:0] w;
        w = '0;
        w[ID_WIDTH-1:0] = id;
        return w[ID_FW-1:0];
    endfunction

    // low bits of the count into the port field
    function automatic logic [COUNT_FW-1:0] cnt_to_field(input t_cnt c);
        logic [COUNT_FW+CNT_W-1:0] w;
        w = '0;
        w[CNT_W-1:0] = c;
        return w[COUNT_FW-1:0];
    endfunction

endpackage

FILE: sv/oidl_cell.sv
// ----------------------------------------------------------------------------
// oidl_cell: one slot of the ordered id list
// Holds one id, compares it against the request id when a request is taken,
// and while the request executes passes the first-match flag and the matched id
// along the chain while shifting its contents with its neighbours.
// ----------------------------------------------------------------------------
module oidl_cell
    import oidl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_idx      i_index,
    input  t_id       i_item_id,
    input  t_id       i_new_id,
    input  t_id       i_left_id,
    input  t_id       i_right_id,
    input  t_cnt      i_count,
    input  logic      i_capture,
    input  t_cell_ctl i_ctl,
    input  logic      i_hit_before,
    input  t_id       i_found_id,
    output logic      o_hit_before,
    output t_id       o_found_id,
    output t_id       o_id
);

    logic r_match;
    t_id  r_id;
    t_id  n_id;
    logic occupied;
    logic at_count;
    logic first;

    // slot position against the list length
    assign occupied = {1'b0, i_index} < {1'b0, i_count};
    assign at_count = {1'b0, i_index} == {1'b0, i_count};

    // priority chain: first match nearest the head
    assign first        = r_match & ~i_hit_before;
    assign o_hit_before = i_hit_before | r_match;
    assign o_found_id   = i_found_id | (first ? r_id : '0);
    assign o_id         = r_id;

    // compare flag taken with the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_capture) begin
            r_match <= occupied && (r_id == i_item_id);
        end
    end

    // slot contents and neighbour shifts
    always_comb begin
        n_id = r_id;
        if (i_ctl.push_tail && at_count) begin
            n_id = i_new_id;
        end else if (i_ctl.push_head) begin
            n_id = i_left_id;
        end else if (i_ctl.pop_head || (i_ctl.remove_hit && o_hit_before)) begin
            n_id = i_right_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

endmodule

FILE: sv/ordered_id_list_engine_unit.sv
// ----------------------------------------------------------------------------
// ordered_id_list_engine_unit: ordered id list with push, pop, remove, find
// Deque of ids with removal and lookup by key, built as a row of list cells.
// ----------------------------------------------------------------------------
// Each request runs through the idle and execute states: in the cycle it is
// taken every cell compares its id against the request id; in the execute
// state the first-match flag and the matched id ripple along the row of
// DEPTH cells, the cells shift in one step and the response is loaded into
// the output register. A response left waiting in that register holds back
// the execute state of the next request, and no new request is taken while
// one executes. Duplicate ids are kept; remove and find act on the match
// nearest the head. A push into a full list is refused with the full status.
// ----------------------------------------------------------------------------
module ordered_id_list_engine_unit
    import oidl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [CMD_FW-1:0]    i_cmd,
    input  logic [ID_FW-1:0]     i_item_id,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [STATUS_FW-1:0] o_status,
    output logic [ID_FW-1:0]     o_result_id,
    output logic [COUNT_FW-1:0]  o_entry_count
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                 r_state;
    logic                 n_state;
    logic [CMD_FW-1:0]    r_cmd;
    t_id                  r_id;
    t_cnt                 r_count;
    t_cnt                 n_count;
    logic                 r_out_valid;
    logic [STATUS_FW-1:0] r_status;
    logic [STATUS_FW-1:0] n_status;
    t_id                  r_result;
    t_id                  n_result;

    logic      accept;
    logic      exec;
    logic      full;
    logic      empty;
    t_cell_ctl ctl;
    t_id       req_id;
    t_idx      tail_idx;
    t_cnt      count_m1;

    logic hit_chain   [DEPTH+1];
    t_id  found_chain [DEPTH+1];
    t_id  cell_ids    [DEPTH];

    // handshake
    assign o_stall = (r_state == ST_EXEC);
    assign accept  = i_valid && !o_stall;
    assign exec    = (r_state == ST_EXEC) && (!r_out_valid || !i_stall);
    assign req_id  = i_item_id[ID_WIDTH-1:0];

    // request sequencing
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (exec) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request hold
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
            r_id  <= req_id;
        end
    end

    // row of list cells
    assign hit_chain[0]   = 1'b0;
    assign found_chain[0] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_id left_id;
        t_id right_id;
        if (g == 0) begin : g_first
            assign left_id = r_id;
        end else begin : g_mid
            assign left_id = cell_ids[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_id = cell_ids[g];
        end else begin : g_body
            assign right_id = cell_ids[g+1];
        end

        oidl_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_index      (IDX_W'(g)),
            .i_item_id    (req_id),
            .i_new_id     (r_id),
            .i_left_id    (left_id),
            .i_right_id   (right_id),
            .i_count      (r_count),
            .i_capture    (accept),
            .i_ctl        (ctl),
            .i_hit_before (hit_chain[g]),
            .i_found_id   (found_chain[g]),
            .o_hit_before (hit_chain[g+1]),
            .o_found_id   (found_chain[g+1]),
            .o_id         (cell_ids[g])
        );
    end

    // command decode and response
    assign full     = (r_count == CNT_W'(DEPTH));
    assign empty    = (r_count == '0);
    assign count_m1 = r_count - CNT_W'(1);
    assign tail_idx = count_m1[IDX_W-1:0];

    always_comb begin
        ctl      = '0;
        n_count  = r_count;
        n_status = STAT_MISS;
        n_result = '0;
        case (r_cmd)
            CMD_PUSH_TAIL, CMD_PUSH_HEAD: begin
                if (full) begin
                    n_status = STAT_FULL;
                end else begin
                    ctl.push_tail = (r_cmd == CMD_PUSH_TAIL);
                    ctl.push_head = (r_cmd == CMD_PUSH_HEAD);
                    n_count  = r_count + CNT_W'(1);
                    n_status = STAT_OK;
                    n_result = r_id;
                end
            end
            CMD_REMOVE: begin
                if (hit_chain[DEPTH]) begin
                    ctl.remove_hit = 1'b1;
                    n_count  = count_m1;
                    n_status = STAT_OK;
                    n_result = found_chain[DEPTH];
                end
            end
            CMD_POP_HEAD: begin
                if (!empty) begin
                    ctl.pop_head = 1'b1;
                    n_count  = count_m1;
                    n_status = STAT_OK;
                    n_result = cell_ids[0];
                end
            end
            CMD_POP_TAIL: begin
                if (!empty) begin
                    n_count  = count_m1;
                    n_status = STAT_OK;
                    n_result = cell_ids[tail_idx];
                end
            end
            CMD_FIND: begin
                if (hit_chain[DEPTH]) begin
                    n_status = STAT_OK;
                    n_result = found_chain[DEPTH];
                end
            end
            default: begin
                n_status = STAT_MISS;
            end
        endcase
        if (!exec) begin
            ctl = '0;
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (exec) begin
            r_count <= n_count;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_status <= n_status;
            r_result <= n_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_result_id   = id_to_field(r_result);
    assign o_entry_count = cnt_to_field(r_count);

endmodule

FILE: sv/oidl_checker.sv
// ----------------------------------------------------------------------------
// oidl_checker: port-level checks for the ordered id list engine
// Watches the top level ports only and is attached to it by a bind.
// ----------------------------------------------------------------------------
module oidl_checker
    import oidl_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [STATUS_FW-1:0] o_status,
    input logic [ID_FW-1:0]     o_result_id,
    input logic [COUNT_FW-1:0]  o_entry_count
);

    // a waiting response keeps its fields
    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status)
            && $stable(o_result_id) && $stable(o_entry_count))
        else $error("response changed while held");

    // failed requests carry no id
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != STAT_OK) |-> o_result_id == '0)
        else $error("nonzero id on a failed request");

    // a refused push only happens with the list at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STAT_FULL) |-> o_entry_count == cnt_to_field(CNT_W'(DEPTH)))
        else $error("full status with list below capacity");

    // a request in progress blocks the next one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second request taken during execution");

endmodule

bind ordered_id_list_engine_unit oidl_checker u_oidl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_status      (o_status),
    .o_result_id   (o_result_id),
    .o_entry_count (o_entry_count)
);

FILE: tb/ordered_id_list_engine_unit_test.sv
// ----------------------------------------------------------------------------
// ordered_id_list_engine_unit_test: self-checking bench for the id list engine
// Drives a short table of directed requests (empty list, extreme ids,
// duplicates, full list, removal at the tail) and then random request
// streams that grow and shrink the list, under random and held-off
// back-pressure. Each response is checked against its table row or a local list predictor.
// ----------------------------------------------------------------------------
module ordered_id_list_engine_unit_test
    import oidl_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // unused command codes, answered with the miss status
    localparam logic [CMD_FW-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_FW-1:0] CMD_SPARE_HI = 3'd7;

    // ids used by the directed table
    localparam logic [ID_FW-1:0] ID_ONES = '1;
    localparam logic [ID_FW-1:0] ID_ZERO = '0;
    localparam logic [ID_FW-1:0] ID_ALT  = 64'h5555_5555_5555_5555;
    localparam logic [ID_FW-1:0] ID_FILL = 64'hAAAA_AAAA_AAAA_0000;
    localparam logic [ID_FW-1:0] ID_MISS = 64'h0000_0000_0000_1234;

    localparam logic [COUNT_FW-1:0] CNT_FULL = COUNT_FW'(DEPTH);
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        logic [STATUS_FW-1:0] status;
        logic [ID_FW-1:0]     rid;
        logic [COUNT_FW-1:0]  cnt;
    } t_reply;

    typedef struct {
        logic [CMD_FW-1:0] cmd;
        logic [ID_FW-1:0]  id;
        int                reps;
        bit                typed;
        t_reply            reply;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [CMD_FW-1:0]    i_cmd = '0;
    logic [ID_FW-1:0]     i_item_id = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [STATUS_FW-1:0] o_status;
    logic [ID_FW-1:0]     o_result_id;
    logic [COUNT_FW-1:0]  o_entry_count;

    // typed expectation travelling with the request on the input side
    bit     req_typed = 1'b0;
    t_reply req_reply = '0;

    t_id    list_ids[$];
    t_reply pending_replies[$];
    t_row   plan[$];
    int     fail_count = 0;
    int     cycle_count = 0;
    int     rx_idle_pct = 0;
    bit     hold_req = 1'b0;
    bit     hold_taken = 1'b0;
    int     hold_left = 0;
    t_reply got_reply;
    t_reply want_reply;

    ordered_id_list_engine_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_item_id     (i_item_id),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_result_id   (o_result_id),
        .o_entry_count (o_entry_count)
    );

    // 2 ns clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // list predictor: applies one request, returns the response
    function automatic t_reply list_apply(input logic [CMD_FW-1:0] cmd,
                                          input logic [ID_FW-1:0] raw_id);
        t_reply r;
        t_id    key;
        int     hit;
        key = t_id'(raw_id);
        hit = -1;
        r = '0;
        r.status = STAT_MISS;
        for (int k = 0; k < list_ids.size(); k++) begin
            if (hit < 0 && list_ids[k] == key) hit = k;
        end
        case (cmd)
            CMD_PUSH_TAIL, CMD_PUSH_HEAD: begin
                if (list_ids.size() >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    if (cmd == CMD_PUSH_TAIL) list_ids.push_back(key);
                    else list_ids.push_front(key);
                    r.status = STAT_OK;
                    r.rid = ID_FW'(key);
                end
            end
            CMD_REMOVE: begin
                if (hit >= 0) begin
                    r.rid = ID_FW'(list_ids[hit]);
                    list_ids.delete(hit);
                    r.status = STAT_OK;
                end
            end
            CMD_POP_HEAD: begin
                if (list_ids.size() > 0) begin
                    r.rid = ID_FW'(list_ids.pop_front());
                    r.status = STAT_OK;
                end
            end
            CMD_POP_TAIL: begin
                if (list_ids.size() > 0) begin
                    r.rid = ID_FW'(list_ids.pop_back());
                    r.status = STAT_OK;
                end
            end
            CMD_FIND: begin
                if (hit >= 0) begin
                    r.rid = ID_FW'(list_ids[hit]);
                    r.status = STAT_OK;
                end
            end
            default: begin
            end
        endcase
        r.cnt = COUNT_FW'(list_ids.size());
        return r;
    endfunction

    // response check first, then log the request taken at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got_reply = '{o_status, o_result_id, o_entry_count};
                if (pending_replies.size() == 0) begin
                    $error("response with none outstanding: status %0d id %h count %0d",
                           o_status, o_result_id, o_entry_count);
                    fail_count++;
                end else begin
                    want_reply = pending_replies.pop_front();
                    if (got_reply.status !== want_reply.status) begin
                        $error("status: expected %0d, got %0d",
                               want_reply.status, got_reply.status);
                        fail_count++;
                    end
                    if (got_reply.rid !== want_reply.rid) begin
                        $error("result_id: expected %h, got %h",
                               want_reply.rid, got_reply.rid);
                        fail_count++;
                    end
                    if (got_reply.cnt !== want_reply.cnt) begin
                        $error("entry_count: expected %0d, got %0d",
                               want_reply.cnt, got_reply.cnt);
                        fail_count++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                want_reply = list_apply(i_cmd, i_item_id);
                pending_replies.push_back(req_typed ? req_reply : want_reply);
            end
        end
    end

    // response side back-pressure, with an occasional long hold-off
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_left = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // offer one request after a random gap and wait until it is taken
    task automatic send_req(input logic [CMD_FW-1:0] cmd, input logic [ID_FW-1:0] id,
                            input bit typed, input t_reply reply, input int gap_pct);
        int gap;
        gap = 0;
        while ($urandom_range(99) < gap_pct && gap < 12) gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_cmd     <= cmd;
        i_item_id <= id;
        req_typed <= typed;
        req_reply <= reply;
        do @(posedge i_clk); while (o_stall);
    endtask

    // stop offering and wait for every outstanding response
    task automatic drain_replies();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_row(input logic [CMD_FW-1:0] cmd, input logic [ID_FW-1:0] id,
                           input int reps, input bit typed,
                           input logic [STATUS_FW-1:0] st, input logic [ID_FW-1:0] rid,
                           input logic [COUNT_FW-1:0] cnt);
        t_row row;
        row.cmd = cmd;
        row.id = id;
        row.reps = reps;
        row.typed = typed;
        row.reply = '{st, rid, cnt};
        plan.push_back(row);
    endtask

    // ids: mostly ones already listed or from a small pool, so hits are common
    function automatic logic [ID_FW-1:0] pick_id();
        int r;
        r = $urandom_range(99);
        if (r < 40 && list_ids.size() > 0)
            return ID_FW'(list_ids[$urandom_range(list_ids.size() - 1)]);
        if (r < 75)
            return ID_FW'($urandom_range(15));
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [CMD_FW-1:0] pick_cmd(input int grow_pct);
        int r;
        r = $urandom_range(99);
        if (r < grow_pct)
            return ($urandom_range(1) != 0) ? CMD_PUSH_HEAD : CMD_PUSH_TAIL;
        r = $urandom_range(99);
        if (r < 28) return CMD_REMOVE;
        if (r < 52) return CMD_FIND;
        if (r < 74) return CMD_POP_HEAD;
        if (r < 96) return CMD_POP_TAIL;
        return r[0] ? CMD_SPARE_HI : CMD_SPARE_LO;
    endfunction

    // random requests, alternating between filling and emptying the list
    task automatic run_random(input int count, input int tx_pct, input int rx_pct);
        int grow;
        rx_idle_pct = rx_pct;
        for (int n = 0; n < count; n++) begin
            grow = ((n / 48) % 2 == 0) ? 72 : 30;
            send_req(pick_cmd(grow), pick_id(), 1'b0, '0, tx_pct);
        end
    endtask

    // main sequence
    initial begin
        // directed table: empty list, extremes, duplicates, full list, tail removal
        add_row(CMD_POP_HEAD,  ID_ZERO, 1, 1, STAT_MISS, ID_ZERO, 0);
        add_row(CMD_POP_TAIL,  ID_ONES, 1, 1, STAT_MISS, ID_ZERO, 0);
        add_row(CMD_REMOVE,    ID_ALT,  1, 1, STAT_MISS, ID_ZERO, 0);
        add_row(CMD_FIND,      ID_ONES, 1, 1, STAT_MISS, ID_ZERO, 0);
        add_row(CMD_SPARE_LO,  ID_ZERO, 1, 1, STAT_MISS, ID_ZERO, 0);
        add_row(CMD_SPARE_HI,  ID_ONES, 1, 1, STAT_MISS, ID_ZERO, 0);
        add_row(CMD_PUSH_TAIL, ID_ONES, 1, 1, STAT_OK,   ID_ONES, 1);
        add_row(CMD_PUSH_HEAD, ID_ZERO, 1, 1, STAT_OK,   ID_ZERO, 2);
        add_row(CMD_PUSH_TAIL, ID_ONES, 1, 1, STAT_OK,   ID_ONES, 3);
        add_row(CMD_FIND,      ID_ONES, 1, 1, STAT_OK,   ID_ONES, 3);
        add_row(CMD_PUSH_TAIL, ID_ALT,  1, 0, STAT_OK,   ID_ZERO, 0);
        add_row(CMD_POP_TAIL,  ID_ZERO, 1, 1, STAT_OK,   ID_ALT,  3);
        // tail pop with the same id also earlier in the list
        add_row(CMD_POP_TAIL,  ID_ZERO, 1, 1, STAT_OK,   ID_ONES, 2);
        add_row(CMD_FIND,      ID_MISS, 1, 1, STAT_MISS, ID_ZERO, 2);
        add_row(CMD_REMOVE,    ID_ZERO, 1, 1, STAT_OK,   ID_ZERO, 1);
        add_row(CMD_POP_HEAD,  ID_ALT,  1, 1, STAT_OK,   ID_ONES, 0);
        add_row(CMD_PUSH_TAIL, ID_FILL, DEPTH, 0, STAT_OK, ID_ZERO, 0);
        add_row(CMD_PUSH_TAIL, ID_MISS, 1, 1, STAT_FULL, ID_ZERO, CNT_FULL);
        add_row(CMD_PUSH_HEAD, ID_ONES, 1, 1, STAT_FULL, ID_ZERO, CNT_FULL);
        add_row(CMD_REMOVE,    ID_FILL + 16, 1, 0, STAT_OK, ID_ZERO, 0);
        add_row(CMD_PUSH_HEAD, ID_ALT,  1, 0, STAT_OK,   ID_ZERO, 0);
        add_row(CMD_PUSH_HEAD, ID_ZERO, 1, 1, STAT_FULL, ID_ZERO, CNT_FULL);
        add_row(CMD_FIND,      ID_ALT,  1, 1, STAT_OK,   ID_ALT,  CNT_FULL);
        // remove the entry at the tail of a full list
        add_row(CMD_REMOVE,    ID_FILL + DEPTH - 1, 1, 0, STAT_OK, ID_ZERO, 0);
        add_row(CMD_POP_HEAD,  ID_ZERO, DEPTH - 2, 0, STAT_OK, ID_ZERO, 0);
        add_row(CMD_POP_TAIL,  ID_ZERO, 1, 0, STAT_OK,   ID_ZERO, 0);

        // hold reset, then release it at a falling edge
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        rx_idle_pct = 35;
        foreach (plan[p]) begin
            for (int k = 0; k < plan[p].reps; k++) begin
                send_req(plan[p].cmd, plan[p].id + k, plan[p].typed, plan[p].reply, 35);
            end
        end

        // random traffic with idling on both sides
        run_random(250, 35, 35);
        // long stretch without idling
        run_random(200, 0, 0);
        // receiver holds off while requests keep coming
        hold_req = 1'b1;
        run_random(100, 5, 35);
        // sender pauses until the list engine has answered everything
        drain_replies();
        run_random(114, 35, 35);

        drain_replies();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/oidl_pkg.sv
sv/oidl_cell.sv
sv/ordered_id_list_engine_unit.sv
sv/oidl_checker.sv
tb/ordered_id_list_engine_unit_test.sv
